[rtl/svpwm_pkg.sv]
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, fixed-point constants, sector codes and divider bundles for
// the center-aligned space vector PWM timing core.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Default compare point width (Q0.DUTY_BITS)
  localparam int DUTY_BITS_DEF = 16;

  // Width of one input field
  localparam int IN_W = 16;

  // Working fraction bits of the active times
  localparam int WORK_FRAC = 26;

  // Signed width of X, Y, Z and the active times
  localparam int T_W = 35;

  // Magnitude width of an active time
  localparam int MAG_W = 34;

  // Divisor width (period sum, always positive)
  localparam int DEN_W = 35;

  // Quotient bits produced by the divider, one per stage
  localparam int Q_BITS = 34;

  // Dividend width: magnitude scaled by one period
  localparam int NUM_W = MAG_W + WORK_FRAC;

  // sqrt3, sqrt3/2 and 1.5 with 16 fraction bits
  localparam logic signed [17:0] K_SQRT3      = 18'sd113512;
  localparam logic signed [17:0] K_SQRT3_HALF = 18'sd56756;
  localparam logic signed [17:0] K_THREE_HALF = 18'sd98304;

  // Sector codes from the projection sign bits
  typedef logic [2:0] sector_t;
  localparam sector_t SEC_ZERO = 3'd0;
  localparam sector_t SEC_1    = 3'd1;
  localparam sector_t SEC_2    = 3'd2;
  localparam sector_t SEC_3    = 3'd3;
  localparam sector_t SEC_4    = 3'd4;
  localparam sector_t SEC_5    = 3'd5;
  localparam sector_t SEC_6    = 3'd6;
  localparam sector_t SEC_BAD  = 3'd7;

  // Item entering the divider: two magnitudes over one shared divisor
  typedef struct packed {
    logic [MAG_W-1:0] mag1;
    logic [MAG_W-1:0] mag2;
    logic             neg1;
    logic             neg2;
    logic [DEN_W-1:0] den;
    sector_t          sector;
    logic             om;
  } div_in_t;

  // Item leaving the divider: signed scaled active times
  typedef struct packed {
    logic [T_W-1:0] q1;
    logic [T_W-1:0] q2;
    sector_t        sector;
    logic           om;
  } div_out_t;

endpackage

[rtl/svpwm_div.sv]
// ----------------------------------------------------------------------------
// svpwm_div
// Pipelined restoring divider: two numerators over a common divisor, one
// quotient bit per stage, quotient truncated toward zero. A final stage
// restores the sign. All stages advance together on en.
// ----------------------------------------------------------------------------
module svpwm_div
  import svpwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  div_in_t  din,
  output logic     out_valid,
  output div_out_t dout
);

  // Magnitude bits below the first partial remainder
  localparam int SKIP = Q_BITS - WORK_FRAC;
  localparam int LAST = Q_BITS - 1;

  logic [Q_BITS-1:0] vld;
  logic [Q_BITS-1:0] vld_next;
  div_in_t           ctl       [Q_BITS];
  div_in_t           ctl_next  [Q_BITS];
  logic [DEN_W-1:0]  rem1      [Q_BITS];
  logic [DEN_W-1:0]  rem2      [Q_BITS];
  logic [DEN_W-1:0]  rem1_next [Q_BITS];
  logic [DEN_W-1:0]  rem2_next [Q_BITS];
  logic [Q_BITS-1:0] quo1      [Q_BITS];
  logic [Q_BITS-1:0] quo2      [Q_BITS];
  logic [Q_BITS-1:0] quo1_next [Q_BITS];
  logic [Q_BITS-1:0] quo2_next [Q_BITS];

  logic [T_W-1:0]    qm1;
  logic [T_W-1:0]    qm2;

  // One shift-subtract step per stage
  always_comb begin : p_step
    div_in_t           c;
    logic [DEN_W-1:0]  r1;
    logic [DEN_W-1:0]  r2;
    logic [Q_BITS-1:0] qa;
    logic [Q_BITS-1:0] qb;
    logic [NUM_W-1:0]  n1;
    logic [NUM_W-1:0]  n2;
    logic [DEN_W:0]    tr1;
    logic [DEN_W:0]    tr2;
    logic [DEN_W:0]    dd;
    for (int k = 0; k < Q_BITS; k++) begin
      if (k == 0) begin
        c           = din;
        r1          = DEN_W'(din.mag1 >> SKIP);
        r2          = DEN_W'(din.mag2 >> SKIP);
        qa          = '0;
        qb          = '0;
        vld_next[k] = in_valid;
      end else begin
        c           = ctl[k-1];
        r1          = rem1[k-1];
        r2          = rem2[k-1];
        qa          = quo1[k-1];
        qb          = quo2[k-1];
        vld_next[k] = vld[k-1];
      end
      n1  = {c.mag1, {WORK_FRAC{1'b0}}};
      n2  = {c.mag2, {WORK_FRAC{1'b0}}};
      dd  = {1'b0, c.den};
      tr1 = {r1, n1[Q_BITS-1-k]};
      tr2 = {r2, n2[Q_BITS-1-k]};
      if (tr1 >= dd) begin
        rem1_next[k] = DEN_W'(tr1 - dd);
        quo1_next[k] = {qa[Q_BITS-2:0], 1'b1};
      end else begin
        rem1_next[k] = DEN_W'(tr1);
        quo1_next[k] = {qa[Q_BITS-2:0], 1'b0};
      end
      if (tr2 >= dd) begin
        rem2_next[k] = DEN_W'(tr2 - dd);
        quo2_next[k] = {qb[Q_BITS-2:0], 1'b1};
      end else begin
        rem2_next[k] = DEN_W'(tr2);
        quo2_next[k] = {qb[Q_BITS-2:0], 1'b0};
      end
      ctl_next[k] = c;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      ctl  <= ctl_next;
      rem1 <= rem1_next;
      rem2 <= rem2_next;
      quo1 <= quo1_next;
      quo2 <= quo2_next;
    end
  end

  // Sign restore on the finished quotients
  assign qm1 = T_W'(quo1[LAST]);
  assign qm2 = T_W'(quo2[LAST]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.q1     <= ctl[LAST].neg1 ? (T_W'(0) - qm1) : qm1;
      dout.q2     <= ctl[LAST].neg2 ? (T_W'(0) - qm2) : qm2;
      dout.sector <= ctl[LAST].sector;
      dout.om     <= ctl[LAST].om;
    end
  end

endmodule

[rtl/space_vector_pwm_timing_core.sv]
// ----------------------------------------------------------------------------
// space_vector_pwm_timing_core
// Throughput: one item per cycle while the skid entry is empty; the divider's
// 34 quotient stages (one quotient bit per stage) set the depth. A two-entry
// output buffer parts s_tready from m_tready.
// Reset: rst (synchronous) clears all valid bits and the output buffer.
// ----------------------------------------------------------------------------
module space_vector_pwm_timing_core
  import svpwm_pkg::*;
#(
  parameter  int DUTY_BITS = DUTY_BITS_DEF,
  localparam int OUT_W     = ((3 * DUTY_BITS + 11) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [3*IN_W-1:0] s_tdata,   // ualpha, ubeta, inv_vdc
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // duty_a, duty_b, duty_c, sector, overmod, zero pad
);

  // Projection width, sign-test width, product width, final working width
  localparam int V_W    = 34;
  localparam int SW     = V_W + 1;
  localparam int PR_W   = V_W + IN_W + 1;
  localparam int CW     = T_W + 3;
  localparam int PSHIFT = 16;
  localparam int SH     = WORK_FRAC - DUTY_BITS;

  localparam logic signed [PR_W-1:0] RND_P = PR_W'(1) <<< (PSHIFT - 1);
  localparam logic signed [CW-1:0]   RND_D = CW'(1) <<< (SH - 1);
  localparam logic signed [T_W:0]    ONE_S = (T_W + 1)'(1) <<< WORK_FRAC;
  localparam logic [DEN_W-1:0]       ONE_D = DEN_W'(1) << WORK_FRAC;
  localparam logic [DUTY_BITS-1:0]   HALF  = DUTY_BITS'(1) << (DUTY_BITS - 1);

  // Pipeline enable and output buffer
  logic             en;
  logic             push;
  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;
  logic [OUT_W-1:0] res_word;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Stage 1: scale inputs, sector from projection signs
  logic signed [IN_W-1:0] in_ua;
  logic signed [IN_W-1:0] in_ub;
  logic [IN_W-1:0]        in_inv;
  logic signed [SW-1:0]   sq_ua;
  logic signed [SW-1:0]   ub_sh;
  logic signed [SW-1:0]   d_pos;
  logic signed [SW-1:0]   d_neg;
  sector_t                sec_in;

  assign in_ua  = s_tdata[IN_W-1:0];
  assign in_ub  = s_tdata[2*IN_W-1:IN_W];
  assign in_inv = s_tdata[3*IN_W-1:2*IN_W];

  always_comb begin
    sq_ua  = SW'(in_ua) * SW'(K_SQRT3);
    ub_sh  = SW'(in_ub) <<< PSHIFT;
    d_pos  = sq_ua - ub_sh;
    d_neg  = (SW'(0) - sq_ua) - ub_sh;
    sec_in = {(d_neg > 0), (d_pos > 0), (in_ub > 0)};
  end

  logic                  s1_v;
  logic signed [V_W-1:0] s1_a;
  logic signed [V_W-1:0] s1_p;
  logic [IN_W-1:0]       s1_inv;
  sector_t               s1_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a   <= V_W'(in_ua) * V_W'(K_THREE_HALF);
      s1_p   <= V_W'(in_ub) * V_W'(K_SQRT3_HALF);
      s1_inv <= in_inv;
      s1_sec <= sec_in;
    end
  end

  // Stage 2: X, Y, Z before the bus scale
  logic                  s2_v;
  logic signed [V_W-1:0] s2_vx;
  logic signed [V_W-1:0] s2_vy;
  logic signed [V_W-1:0] s2_vz;
  logic [IN_W-1:0]       s2_inv;
  sector_t               s2_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vx  <= s1_p <<< 1;
      s2_vy  <= s1_a + s1_p;
      s2_vz  <= s1_p - s1_a;
      s2_inv <= s1_inv;
      s2_sec <= s1_sec;
    end
  end

  // Stage 3: multiply by 1/Vdc
  logic signed [PR_W-1:0] inv_s;
  logic                   s3_v;
  logic signed [PR_W-1:0] s3_px;
  logic signed [PR_W-1:0] s3_py;
  logic signed [PR_W-1:0] s3_pz;
  sector_t                s3_sec;

  assign inv_s = PR_W'($signed({1'b0, s2_inv}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_px  <= PR_W'(s2_vx) * inv_s;
      s3_py  <= PR_W'(s2_vy) * inv_s;
      s3_pz  <= PR_W'(s2_vz) * inv_s;
      s3_sec <= s2_sec;
    end
  end

  // Stage 4: round half up to Q26
  logic signed [PR_W-1:0] rx;
  logic signed [PR_W-1:0] ry;
  logic signed [PR_W-1:0] rz;
  logic                   s4_v;
  logic signed [T_W-1:0]  s4_x;
  logic signed [T_W-1:0]  s4_y;
  logic signed [T_W-1:0]  s4_z;
  sector_t                s4_sec;

  always_comb begin
    rx = (s3_px + RND_P) >>> PSHIFT;
    ry = (s3_py + RND_P) >>> PSHIFT;
    rz = (s3_pz + RND_P) >>> PSHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x   <= rx[T_W-1:0];
      s4_y   <= ry[T_W-1:0];
      s4_z   <= rz[T_W-1:0];
      s4_sec <= s3_sec;
    end
  end

  // Stage 5: pick the two active times by sector
  logic signed [T_W-1:0] t1_sel;
  logic signed [T_W-1:0] t2_sel;
  logic                  s5_v;
  logic signed [T_W-1:0] s5_t1;
  logic signed [T_W-1:0] s5_t2;
  sector_t               s5_sec;

  always_comb begin
    case (s4_sec)
      SEC_1: begin
        t1_sel = s4_z;
        t2_sel = s4_y;
      end
      SEC_2: begin
        t1_sel = s4_y;
        t2_sel = -s4_x;
      end
      SEC_3: begin
        t1_sel = -s4_z;
        t2_sel = s4_x;
      end
      SEC_4: begin
        t1_sel = -s4_x;
        t2_sel = s4_z;
      end
      SEC_5: begin
        t1_sel = s4_x;
        t2_sel = -s4_y;
      end
      SEC_6: begin
        t1_sel = -s4_y;
        t2_sel = -s4_z;
      end
      default: begin
        t1_sel = '0;
        t2_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t1  <= t1_sel;
      s5_t2  <= t2_sel;
      s5_sec <= s4_sec;
    end
  end

  // Stage 6: overmodulation test, divisor and magnitudes for the divider
  logic signed [T_W:0]   tsum;
  logic                  om_in;
  logic signed [T_W-1:0] nt1;
  logic signed [T_W-1:0] nt2;
  div_in_t               div_next;
  logic                  s6_v;
  div_in_t               s6_div;

  always_comb begin
    tsum            = (T_W + 1)'(s5_t1) + (T_W + 1)'(s5_t2);
    om_in           = tsum > ONE_S;
    nt1             = -s5_t1;
    nt2             = -s5_t2;
    div_next.neg1   = s5_t1[T_W-1];
    div_next.neg2   = s5_t2[T_W-1];
    div_next.mag1   = s5_t1[T_W-1] ? nt1[MAG_W-1:0] : s5_t1[MAG_W-1:0];
    div_next.mag2   = s5_t2[T_W-1] ? nt2[MAG_W-1:0] : s5_t2[MAG_W-1:0];
    // a divisor of one period leaves the time unchanged
    div_next.den    = om_in ? tsum[DEN_W-1:0] : ONE_D;
    div_next.sector = s5_sec;
    div_next.om     = om_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_div <= div_next;
    end
  end

  // Rescale both active times
  logic     dv_v;
  div_out_t dv_out;

  svpwm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .din       (s6_div),
    .out_valid (dv_v),
    .dout      (dv_out)
  );

  // F1: zero-vector time
  logic                  f1_v;
  logic signed [CW-1:0]  f1_s;
  logic signed [T_W-1:0] f1_q1;
  logic signed [T_W-1:0] f1_q2;
  sector_t               f1_sec;
  logic                  f1_om;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_s   <= CW'(ONE_S) - CW'($signed(dv_out.q1)) - CW'($signed(dv_out.q2));
      f1_q1  <= dv_out.q1;
      f1_q2  <= dv_out.q2;
      f1_sec <= dv_out.sector;
      f1_om  <= dv_out.om;
    end
  end

  // F2: Ta (halved toward minus infinity) and Tb
  logic signed [CW-1:0]  ta_half;
  logic                  f2_v;
  logic signed [CW-1:0]  f2_ta;
  logic signed [CW-1:0]  f2_tb;
  logic signed [T_W-1:0] f2_q2;
  sector_t               f2_sec;
  logic                  f2_om;

  assign ta_half = f1_s >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_ta  <= ta_half;
      f2_tb  <= ta_half + CW'(f1_q1);
      f2_q2  <= f1_q2;
      f2_sec <= f1_sec;
      f2_om  <= f1_om;
    end
  end

  // F3: Tc
  logic                 f3_v;
  logic signed [CW-1:0] f3_ta;
  logic signed [CW-1:0] f3_tb;
  logic signed [CW-1:0] f3_tc;
  sector_t              f3_sec;
  logic                 f3_om;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_v <= 1'b0;
    end else if (en) begin
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_ta  <= f2_ta;
      f3_tb  <= f2_tb;
      f3_tc  <= f2_tb + CW'(f2_q2);
      f3_sec <= f2_sec;
      f3_om  <= f2_om;
    end
  end

  // F4: round half up to duty bits and saturate
  function automatic logic [DUTY_BITS-1:0] to_duty(input logic signed [CW-1:0] t);
    logic signed [CW-1:0] r;
    r = (t + RND_D) >>> SH;
    if (r[CW-1]) begin
      return '0;
    end else if (|r[CW-2:DUTY_BITS]) begin
      return '1;
    end else begin
      return r[DUTY_BITS-1:0];
    end
  endfunction

  logic                 f4_v;
  logic [DUTY_BITS-1:0] f4_da;
  logic [DUTY_BITS-1:0] f4_db;
  logic [DUTY_BITS-1:0] f4_dc;
  sector_t              f4_sec;
  logic                 f4_om;

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_v <= 1'b0;
    end else if (en) begin
      f4_v <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_da  <= to_duty(f3_ta);
      f4_db  <= to_duty(f3_tb);
      f4_dc  <= to_duty(f3_tc);
      f4_sec <= f3_sec;
      f4_om  <= f3_om;
    end
  end

  // Route compare points to phases
  logic [DUTY_BITS-1:0] ca;
  logic [DUTY_BITS-1:0] cb;
  logic [DUTY_BITS-1:0] cc;

  always_comb begin
    case (f4_sec)
      SEC_1: begin
        ca = f4_db;
        cb = f4_da;
        cc = f4_dc;
      end
      SEC_2: begin
        ca = f4_da;
        cb = f4_dc;
        cc = f4_db;
      end
      SEC_3: begin
        ca = f4_da;
        cb = f4_db;
        cc = f4_dc;
      end
      SEC_4: begin
        ca = f4_dc;
        cb = f4_db;
        cc = f4_da;
      end
      SEC_5: begin
        ca = f4_dc;
        cb = f4_da;
        cc = f4_db;
      end
      SEC_6: begin
        ca = f4_db;
        cb = f4_dc;
        cc = f4_da;
      end
      default: begin
        ca = HALF;
        cb = HALF;
        cc = HALF;
      end
    endcase
  end

  assign res_word = OUT_W'({f4_om, f4_sec, cc, cb, ca});
  assign push     = en && f4_v;

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (m_tready) begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (m_tvalid && !m_tready) begin
          skid_valid <= 1'b1;
        end else begin
          m_tvalid <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid_data;
      end
    end else if (push) begin
      if (m_tvalid && !m_tready) begin
        skid_data <= res_word;
      end else begin
        m_tdata <= res_word;
      end
    end
  end

endmodule

[rtl/svpwm_chk.sv]
// ----------------------------------------------------------------------------
// svpwm_chk
// Port-level checks for the space vector PWM timing core, bound to the top.
// ----------------------------------------------------------------------------
module svpwm_chk
  import svpwm_pkg::*;
#(
  parameter  int DUTY_BITS = DUTY_BITS_DEF,
  localparam int OUT_W     = ((3 * DUTY_BITS + 11) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata   // duty_a, duty_b, duty_c, sector, overmod, zero pad
);

  localparam int SEC_LO = 3 * DUTY_BITS;
  localparam int OM_BIT = SEC_LO + 3;
  localparam logic [DUTY_BITS-1:0] HALF = DUTY_BITS'(1) << (DUTY_BITS - 1);

  logic [DUTY_BITS-1:0] o_a;
  logic [DUTY_BITS-1:0] o_b;
  logic [DUTY_BITS-1:0] o_c;
  sector_t              o_sec;
  logic                 o_om;

  assign o_a   = m_tdata[DUTY_BITS-1:0];
  assign o_b   = m_tdata[2*DUTY_BITS-1:DUTY_BITS];
  assign o_c   = m_tdata[3*DUTY_BITS-1:2*DUTY_BITS];
  assign o_sec = m_tdata[SEC_LO+2:SEC_LO];
  assign o_om  = m_tdata[OM_BIT];

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input side only stalls while a result is pending
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // All three projections cannot be positive together
  a_sector: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_sec != SEC_BAD)
    else $error("impossible sector code");

  // Zero vector: centered compare points, no rescale
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_sec == SEC_ZERO |-> !o_om && o_a == HALF && o_b == HALF && o_c == HALF)
    else $error("zero vector result not centered");

endmodule

bind space_vector_pwm_timing_core svpwm_chk #(.DUTY_BITS(DUTY_BITS)) u_svpwm_chk (.*);
